// ----- rtl/brf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the byte ring FIFO with pattern seek.
// No dependencies; compiled first.
package brf_pkg;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int AMT_W       = 11;
    localparam int OFF_W       = 10;
    localparam int LVL_W       = 11;
    localparam int PAT_W       = 64;
    localparam int PLEN_W      = 4;
    localparam int MAX_PATTERN = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int Q_DEPTH     = 2;

    localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DISCARD = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEEK    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CLEAR   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_OVERWRITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLEN      = 2'd2;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK,
        OP_DISCARD,
        OP_SEEK,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic {
        S_RUN,
        S_SEEK
    } t_bstate;

    typedef struct packed {
        logic              overwrite;
        logic [PAT_W-1:0]  pattern;
        logic [PLEN_W-1:0] plen;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] data;
        logic [AMT_W-1:0]  amount;
        logic              last;
    } t_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] data_out;
        logic              data_valid;
        logic              accepted;
        logic              overwrote;
        logic              found;
        logic [OFF_W-1:0]  match_offset;
        logic [LVL_W-1:0]  discarded;
        logic [LVL_W-1:0]  fill_level;
        logic              burst_last;
    } t_res;

endpackage

// ----- rtl/brf_if.sv -----
`timescale 1ns / 1ps
// Request and result channels of the byte ring FIFO, valid/ready handshake.
// Depends on brf_pkg.
interface brf_item_if;
    import brf_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_in;
    logic [AMT_W-1:0]  amount;
    logic              burst_last_in;

    modport source (output valid, kind, data_in, amount, burst_last_in, input ready);
    modport sink   (input valid, kind, data_in, amount, burst_last_in, output ready);
endinterface

interface brf_res_if;
    import brf_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_out;
    logic              data_valid;
    logic              accepted;
    logic              overwrote;
    logic              found;
    logic [OFF_W-1:0]  match_offset;
    logic [LVL_W-1:0]  discarded;
    logic [LVL_W-1:0]  fill_level;
    logic              burst_last;

    modport source (output valid, data_out, data_valid, accepted, overwrote, found,
                    match_offset, discarded, fill_level, burst_last, input ready);
    modport sink   (input valid, data_out, data_valid, accepted, overwrote, found,
                    match_offset, discarded, fill_level, burst_last, output ready);
endinterface

// ----- rtl/brf_front.sv -----
`timescale 1ns / 1ps
// Front end: accepts requests, decodes the kind and queues commands.
// Depends on brf_pkg and brf_item_if.
module brf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    brf_item_if.sink      i_item,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output brf_pkg::t_cmd o_cmd
);
    import brf_pkg::*;

    t_cmd                         r_q [Q_DEPTH];
    logic [$clog2(Q_DEPTH)-1:0]   r_wp;
    logic [$clog2(Q_DEPTH)-1:0]   r_rp;
    logic [$clog2(Q_DEPTH+1)-1:0] r_cnt;
    t_cmd                         dec;
    logic                         push;
    logic                         pop;

    always_comb begin
        case (i_item.kind)
            KIND_PUSH:    dec.op = OP_PUSH;
            KIND_POP:     dec.op = OP_POP;
            KIND_PEEK:    dec.op = OP_PEEK;
            KIND_DISCARD: dec.op = OP_DISCARD;
            KIND_SEEK:    dec.op = OP_SEEK;
            KIND_CLEAR:   dec.op = OP_CLEAR;
            default:      dec.op = OP_NOP;
        endcase
        dec.data   = i_item.data_in;
        dec.amount = i_item.amount;
        dec.last   = i_item.burst_last_in;
    end

    assign i_item.ready = (r_cnt != ($clog2(Q_DEPTH+1))'(Q_DEPTH));
    assign o_cmd_valid  = (r_cnt != '0);
    assign o_cmd        = r_q[r_rp];
    assign push         = i_item.valid && i_item.ready;
    assign pop          = o_cmd_valid && i_cmd_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- rtl/brf_back.sv -----
`timescale 1ns / 1ps
// Back end: byte store, head and fill state, seek walker and result register.
// Depends on brf_pkg and brf_res_if.
module brf_back #(
    parameter int DEPTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  brf_pkg::t_cmd i_cmd,
    input  brf_pkg::t_cfg i_cfg,
    brf_res_if.source     o_res
);
    import brf_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);
    localparam int SW = PW + 1;
    localparam int CW = (FW > AMT_W) ? FW : AMT_W;

    function automatic logic [PW-1:0] f_wrap(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
        return t[PW-1:0];
    endfunction

    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    t_bstate           r_state, n_state;
    logic [PW-1:0]     r_head, n_head;
    logic [FW-1:0]     r_fill, n_fill;
    logic              r_out_valid, n_out_valid;
    logic              r_out_rd, n_out_rd;
    t_res              r_res, n_res;
    logic [FW-1:0]     r_iss, n_iss;
    logic [FW-1:0]     r_cnt, n_cnt;
    logic              r_rd_vld, n_rd_vld;
    logic [BYTE_W-1:0] r_win [MAX_PATTERN];
    logic [BYTE_W-1:0] n_win [MAX_PATTERN];

    logic              mem_we, mem_re;
    logic [PW-1:0]     mem_waddr, mem_raddr;
    logic              out_free, take, full, amt_ok;
    logic [FW-1:0]     disc_n;
    logic [PW-1:0]     tail, head_p1, head_n, seek_addr;
    logic [PLEN_W-1:0] len;
    logic [MAX_PATTERN-1:0] ok;
    logic [PLEN_W-1:0] pj [MAX_PATTERN];
    logic              found_now, done_nf;
    logic [CW-1:0]     match_off;

    assign out_free    = !r_out_valid || o_res.ready;
    assign o_cmd_ready = (r_state == S_RUN) && out_free;
    assign take        = i_cmd_valid && o_cmd_ready;
    assign full        = (r_fill == FW'(DEPTH));
    assign amt_ok      = CW'(i_cmd.amount) < CW'(r_fill);
    assign disc_n      = amt_ok ? FW'(i_cmd.amount) : r_fill;
    assign tail        = f_wrap(SW'(r_head) + SW'(r_fill));
    assign head_p1     = f_wrap(SW'(r_head) + SW'(1));
    assign head_n      = f_wrap(SW'(r_head) + SW'(disc_n));
    assign seek_addr   = f_wrap(SW'(r_head) + SW'(r_iss));

    always_comb begin
        if (i_cfg.plen == '0) begin
            len = PLEN_W'(1);
        end else if (i_cfg.plen > PLEN_W'(MAX_PATTERN)) begin
            len = PLEN_W'(MAX_PATTERN);
        end else begin
            len = i_cfg.plen;
        end
    end

    // window slot m holds the byte that pattern byte len-1-m must match
    always_comb begin
        for (int m = 0; m < MAX_PATTERN; m++) begin
            pj[m] = len - PLEN_W'(m) - PLEN_W'(1);
            ok[m] = (PLEN_W'(m) >= len) ||
                    (r_win[m] == i_cfg.pattern[{pj[m][2:0], 3'b000} +: BYTE_W]);
        end
    end

    assign found_now = (r_state == S_SEEK) && (CW'(r_cnt) >= CW'(len)) && (&ok);
    assign done_nf   = (r_state == S_SEEK) && (r_cnt == r_fill) && !found_now;
    assign match_off = CW'(r_cnt) - CW'(len);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RUN: begin
                if (take && i_cmd.op == OP_SEEK) begin
                    n_state = S_SEEK;
                end
            end
            S_SEEK: begin
                if (found_now || done_nf) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_head;
        mem_raddr   = r_head;
        n_head      = r_head;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_rd    = r_out_rd;
        n_res       = r_res;
        n_iss       = r_iss;
        n_cnt       = r_cnt;
        n_rd_vld    = 1'b0;
        n_win       = r_win;

        case (r_state)
            S_RUN: begin
                if (take) begin
                    n_res       = '0;
                    n_out_rd    = 1'b0;
                    n_out_valid = 1'b1;
                    case (i_cmd.op)
                        OP_PUSH: begin
                            n_res.burst_last = i_cmd.last;
                            if (!full) begin
                                mem_we         = 1'b1;
                                mem_waddr      = tail;
                                n_fill         = r_fill + FW'(1);
                                n_res.accepted = 1'b1;
                            end else if (i_cfg.overwrite) begin
                                mem_we          = 1'b1;
                                mem_waddr       = r_head;
                                n_head          = head_p1;
                                n_res.accepted  = 1'b1;
                                n_res.overwrote = 1'b1;
                            end
                        end
                        OP_POP: begin
                            n_res.burst_last = i_cmd.last;
                            if (r_fill != '0) begin
                                mem_re           = 1'b1;
                                mem_raddr        = r_head;
                                n_out_rd         = 1'b1;
                                n_res.data_valid = 1'b1;
                                n_head           = head_p1;
                                n_fill           = r_fill - FW'(1);
                            end
                        end
                        OP_PEEK: begin
                            if (amt_ok) begin
                                mem_re           = 1'b1;
                                mem_raddr        = head_n;
                                n_out_rd         = 1'b1;
                                n_res.data_valid = 1'b1;
                            end
                        end
                        OP_DISCARD: begin
                            n_head          = head_n;
                            n_fill          = r_fill - disc_n;
                            n_res.discarded = LVL_W'(disc_n);
                        end
                        OP_SEEK: begin
                            n_out_valid = 1'b0;
                            n_iss       = '0;
                            n_cnt       = '0;
                        end
                        OP_CLEAR: begin
                            n_head = '0;
                            n_fill = '0;
                        end
                        default: ;
                    endcase
                    n_res.fill_level = LVL_W'(n_fill);
                end
            end
            S_SEEK: begin
                if (found_now || done_nf) begin
                    n_out_valid        = 1'b1;
                    n_out_rd           = 1'b0;
                    n_res              = '0;
                    n_res.found        = found_now;
                    n_res.match_offset = found_now ? OFF_W'(match_off) : '0;
                    n_res.fill_level   = LVL_W'(r_fill);
                end else begin
                    if (r_iss != r_fill) begin
                        mem_re    = 1'b1;
                        mem_raddr = seek_addr;
                        n_iss     = r_iss + FW'(1);
                    end
                    n_rd_vld = mem_re;
                    if (r_rd_vld) begin
                        n_win[0] = r_rdata;
                        for (int m = 1; m < MAX_PATTERN; m++) begin
                            n_win[m] = r_win[m-1];
                        end
                        n_cnt = r_cnt + FW'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_win <= n_win;
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
            r_out_rd    <= 1'b0;
            r_iss       <= '0;
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            r_out_rd    <= n_out_rd;
            r_iss       <= n_iss;
            r_cnt       <= n_cnt;
            r_rd_vld    <= n_rd_vld;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.data_out     = r_out_rd ? r_rdata : r_res.data_out;
    assign o_res.data_valid   = r_res.data_valid;
    assign o_res.accepted     = r_res.accepted;
    assign o_res.overwrote    = r_res.overwrote;
    assign o_res.found        = r_res.found;
    assign o_res.match_offset = r_res.match_offset;
    assign o_res.discarded    = r_res.discarded;
    assign o_res.fill_level   = r_res.fill_level;
    assign o_res.burst_last   = r_res.burst_last;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count above capacity");

    a_seek_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEEK |-> !r_out_valid)
        else $error("result pending during seek");

    a_result_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_cmd.op != OP_SEEK) |=> r_out_valid)
        else $error("command gave no result");

    a_seek_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SEEK |-> (r_iss <= r_fill && r_cnt <= r_iss))
        else $error("seek walker out of order");

endmodule

// ----- rtl/byte_ring_fifo_with_seek.sv -----
`timescale 1ns / 1ps
// Byte ring FIFO with pattern seek; requests pass a command queue, then the result register.
// Push, pop, peek, discard and clear run one per cycle unless a result stall or seek holds them.
// Seek holds the back end while it walks the stored bytes: one store read port, one byte a cycle.
// Reset clears head, fill and control state at once; the byte store gets no clearing pass.
// Depends on brf_pkg, brf_if, brf_front and brf_back.
module byte_ring_fifo_with_seek #(
    parameter int DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    brf_item_if.sink                       i_item,
    brf_res_if.source                      o_res,
    input  logic                           i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [brf_pkg::PAT_W-1:0]      i_cfg_wdata
);
    import brf_pkg::*;

    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid;
    logic cmd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.overwrite <= 1'b0;
            r_cfg.pattern   <= '0;
            r_cfg.plen      <= PLEN_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_OVERWRITE: r_cfg.overwrite <= i_cfg_wdata[0];
                CFG_PATTERN:   r_cfg.pattern   <= i_cfg_wdata;
                CFG_PLEN:      r_cfg.plen      <= i_cfg_wdata[PLEN_W-1:0];
                default: ;
            endcase
        end
    end

    brf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    brf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .o_res       (o_res)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for byte_ring_fifo_with_seek: random request and result stalls,
// a scoreboard class that tracks the ring contents and compares every result in order.
// Depends on brf_pkg, brf_if and the RTL of the block.
module tb;
    import brf_pkg::*;

    localparam int          DEPTH       = 1024;
    localparam int unsigned CYCLE_LIMIT = 400_000;

    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data;
        logic [AMT_W-1:0]  amount;
        logic              last;
    } t_req;

    class byte_ring_checker;
        logic [BYTE_W-1:0] ring_bytes [DEPTH];
        int unsigned       head;
        int unsigned       fill;
        logic              overwrite;
        logic [PAT_W-1:0]  pattern;
        logic [PLEN_W-1:0] plen;
        t_res              awaited [$];
        int unsigned       fails, n_req, n_res, n_found, n_over, n_refused, peak_fill;

        function new();
            foreach (ring_bytes[k]) ring_bytes[k] = '0;
            head      = 0;
            fill      = 0;
            overwrite = 1'b0;
            pattern   = '0;
            plen      = 4'd1;
            fails     = 0;
            n_req     = 0;
            n_res     = 0;
            n_found   = 0;
            n_over    = 0;
            n_refused = 0;
            peak_fill = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [PAT_W-1:0] val);
            case (idx)
                CFG_OVERWRITE: overwrite = val[0];
                CFG_PATTERN:   pattern = val;
                CFG_PLEN:      plen = val[PLEN_W-1:0];
                default: ;
            endcase
        endfunction

        function t_res ring_step(t_req q);
            t_res        r;
            int unsigned len, i, j, n;
            logic        hit;
            r = '0;
            case (q.kind)
                KIND_PUSH: begin
                    r.burst_last = q.last;
                    if (fill < DEPTH) begin
                        ring_bytes[(head + fill) % DEPTH] = q.data;
                        fill++;
                        r.accepted = 1'b1;
                    end else if (overwrite) begin
                        ring_bytes[head] = q.data;
                        head = (head + 1) % DEPTH;
                        r.accepted  = 1'b1;
                        r.overwrote = 1'b1;
                        n_over++;
                    end else begin
                        n_refused++;
                    end
                end
                KIND_POP: begin
                    r.burst_last = q.last;
                    if (fill > 0) begin
                        r.data_out   = ring_bytes[head];
                        r.data_valid = 1'b1;
                        head = (head + 1) % DEPTH;
                        fill--;
                    end
                end
                KIND_PEEK: begin
                    if (q.amount < fill) begin
                        r.data_out   = ring_bytes[(head + q.amount) % DEPTH];
                        r.data_valid = 1'b1;
                    end
                end
                KIND_DISCARD: begin
                    n = (q.amount < fill) ? q.amount : fill;
                    head = (head + n) % DEPTH;
                    fill -= n;
                    r.discarded = n[LVL_W-1:0];
                end
                KIND_SEEK: begin
                    len = (plen == 0) ? 1 : (plen > MAX_PATTERN) ? MAX_PATTERN : plen;
                    for (i = 0; i + len <= fill && !r.found; i++) begin
                        hit = 1'b1;
                        for (j = 0; j < len; j++)
                            if (ring_bytes[(head + i + j) % DEPTH] != pattern[8*j +: 8])
                                hit = 1'b0;
                        if (hit) begin
                            r.found        = 1'b1;
                            r.match_offset = i[OFF_W-1:0];
                            n_found++;
                        end
                    end
                end
                KIND_CLEAR: begin
                    head = 0;
                    fill = 0;
                    foreach (ring_bytes[k]) ring_bytes[k] = '0;
                end
                default: ;
            endcase
            if (fill > peak_fill) peak_fill = fill;
            r.fill_level = fill[LVL_W-1:0];
            return r;
        endfunction

        function void note_request(t_req q);
            n_req++;
            awaited.push_back(ring_step(q));
        endfunction

        function void report(string what, logic [15:0] want, logic [15:0] got);
            fails++;
            if (fails <= 10)
                $display("MISMATCH result %0d %s: expected %0h, got %0h",
                         n_res, what, want, got);
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (want !== got) report(what, want, got);
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (awaited.size() == 0) begin
                report("unrequested result, fill_level", '0, got.fill_level);
                return;
            end
            want = awaited.pop_front();
            n_res++;
            compare("data_out", want.data_out, got.data_out);
            compare("data_valid", want.data_valid, got.data_valid);
            compare("accepted", want.accepted, got.accepted);
            compare("overwrote", want.overwrote, got.overwrote);
            compare("found", want.found, got.found);
            compare("match_offset", want.match_offset, got.match_offset);
            compare("discarded", want.discarded, got.discarded);
            compare("fill_level", want.fill_level, got.fill_level);
            compare("burst_last", want.burst_last, got.burst_last);
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [PAT_W-1:0]  cfg_wdata;
    logic              idle_on = 1'b1;
    int unsigned       cycle_count = 0;
    byte_ring_checker  sb;

    brf_item_if req_ch ();
    brf_res_if  res_ch ();

    byte_ring_fifo_with_seek #(.DEPTH(DEPTH)) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.awaited.size());
            $display("byte_ring_fifo_with_seek regression: fail");
            $finish;
        end
    end

    task automatic send(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] data,
                        input logic [AMT_W-1:0] amount, input logic last);
        int   gap;
        t_req q;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.data_in       <= data;
        req_ch.amount        <= amount;
        req_ch.burst_last_in <= last;
        q = '{kind, data, amount, last};
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        sb.note_request(q);
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (sb.awaited.size() != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic ow, input logic [PAT_W-1:0] pat,
                              input logic [PLEN_W-1:0] len);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_OVERWRITE;
        cfg_wdata <= PAT_W'(ow);
        @(posedge clk);
        sb.write_reg(CFG_OVERWRITE, PAT_W'(ow));
        cfg_idx   <= CFG_PATTERN;
        cfg_wdata <= pat;
        @(posedge clk);
        sb.write_reg(CFG_PATTERN, pat);
        cfg_idx   <= CFG_PLEN;
        cfg_wdata <= PAT_W'(len);
        @(posedge clk);
        sb.write_reg(CFG_PLEN, PAT_W'(len));
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned budget, input logic [BYTE_W-1:0] sym_a,
                                input logic [BYTE_W-1:0] sym_b);
        int unsigned       sent, pick, run, k, plant_len, amt;
        logic [BYTE_W-1:0] b;
        sent = 0;
        plant_len = (sb.plen == 0) ? 1 : (sb.plen > MAX_PATTERN) ? MAX_PATTERN : sb.plen;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            // hold the fill small so that seeks stay short
            if (sb.fill > 48 && pick < 33) pick = pick + 33;
            if (pick < 25) begin
                run = $urandom_range(1, 8);
                for (k = 0; k < run; k++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: b = $urandom_range(0, 255);
                        3, 4, 5: b = sym_a;
                        default: b = sym_b;
                    endcase
                    send(KIND_PUSH, b, $urandom_range(0, 2047), k == run - 1);
                end
                sent += run;
            end else if (pick < 33) begin
                for (k = 0; k < plant_len; k++)
                    send(KIND_PUSH, sb.pattern[8*k +: 8], $urandom_range(0, 2047),
                         k == plant_len - 1);
                sent += plant_len;
            end else if (pick < 47) begin
                run = $urandom_range(1, 6);
                for (k = 0; k < run; k++)
                    send(KIND_POP, $urandom_range(0, 255), $urandom_range(0, 2047),
                         k == run - 1);
                sent += run;
            end else if (pick < 62) begin
                case ($urandom_range(0, 4))
                    0, 1, 2: amt = (sb.fill != 0) ? $urandom_range(0, sb.fill - 1) : 0;
                    3:       amt = sb.fill + $urandom_range(0, 3);
                    default: amt = $urandom_range(0, 2047);
                endcase
                send(KIND_PEEK, $urandom_range(0, 255), amt, $urandom_range(0, 1));
                sent++;
            end else if (pick < 70) begin
                case ($urandom_range(0, 6))
                    0:       amt = sb.fill + $urandom_range(0, 5);
                    1:       amt = $urandom_range(0, 2047);
                    default: amt = $urandom_range(0, 4);
                endcase
                send(KIND_DISCARD, $urandom_range(0, 255), amt, $urandom_range(0, 1));
                sent++;
            end else if (pick < 87) begin
                send(KIND_SEEK, $urandom_range(0, 255), $urandom_range(0, 2047),
                     $urandom_range(0, 1));
                sent++;
            end else if (pick < 90) begin
                send(KIND_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047),
                     $urandom_range(0, 1));
                sent++;
            end else if (pick < 95) begin
                send($urandom_range(0, 1) ? KIND_UNUSED_A : KIND_UNUSED_B,
                     $urandom_range(0, 255), $urandom_range(0, 2047), $urandom_range(0, 1));
                sent++;
            end else begin
                send($urandom_range(0, 7), $urandom_range(0, 255), $urandom_range(0, 2047),
                     $urandom_range(0, 1));
                sent++;
            end
        end
    endtask

    initial begin : result_sink
        t_res got;
        int   gap;
        res_ch.ready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (gap != 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (res_ch.valid !== 1'b1);
            got.data_out     = res_ch.data_out;
            got.data_valid   = res_ch.data_valid;
            got.accepted     = res_ch.accepted;
            got.overwrote    = res_ch.overwrote;
            got.found        = res_ch.found;
            got.match_offset = res_ch.match_offset;
            got.discarded    = res_ch.discarded;
            got.fill_level   = res_ch.fill_level;
            got.burst_last   = res_ch.burst_last;
            sb.check_result(got);
        end
    end

    initial begin : stimulus
        int unsigned       k, p;
        logic [BYTE_W-1:0] sym_a, sym_b;
        logic [PAT_W-1:0]  pat;
        logic [PLEN_W-1:0] len;
        sb = new();
        rst_n                <= 1'b0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= KIND_PUSH;
        req_ch.data_in       <= '0;
        req_ch.amount        <= '0;
        req_ch.burst_last_in <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_OVERWRITE;
        cfg_wdata            <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty ring, then a short fill and every kind of request
        send(KIND_POP, 8'h00, 11'd0, 1'b1);
        send(KIND_PEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_DISCARD, 8'h00, 11'h7FF, 1'b0);
        send(KIND_PUSH, 8'h00, 11'd0, 1'b0);
        send(KIND_PUSH, 8'hFF, 11'h7FF, 1'b1);
        send(KIND_PUSH, 8'h80, 11'd0, 1'b0);
        send(KIND_PUSH, 8'h01, 11'd0, 1'b1);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_PEEK, 8'h00, 11'd3, 1'b1);
        send(KIND_PEEK, 8'h00, 11'd4, 1'b0);
        send(KIND_PEEK, 8'h00, 11'h7FF, 1'b0);
        send(KIND_POP, 8'hFF, 11'h7FF, 1'b1);
        send(KIND_DISCARD, 8'h00, 11'd1, 1'b0);
        send(KIND_DISCARD, 8'h00, 11'd0, 1'b0);
        send(KIND_UNUSED_A, 8'hA5, 11'h555, 1'b1);
        send(KIND_UNUSED_B, 8'h5A, 11'h2AA, 1'b0);
        send(KIND_CLEAR, 8'h00, 11'd0, 1'b0);
        send(KIND_POP, 8'h00, 11'd0, 1'b0);

        // zero length saturates to one byte, fifteen to eight
        set_config(1'b1, 64'hFFFF_FFFF_FFFF_FF55, 4'd0);
        send(KIND_PUSH, 8'h55, 11'd0, 1'b0);
        send(KIND_PUSH, 8'hAA, 11'd0, 1'b1);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        set_config(1'b0, '1, 4'd15);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_CLEAR, 8'h00, 11'd0, 1'b0);

        // fill to capacity with the pattern at the very end
        set_config(1'b0, 64'hF7F6_F5F4_F3F2_F1F0, 4'd8);
        for (k = 0; k < DEPTH - MAX_PATTERN; k++) begin
            idle_on = ((k / 256) % 2) == 0;
            send(KIND_PUSH, $urandom_range(0, 127), $urandom_range(0, 2047), (k % 64) == 63);
            if ((k % 128) == 127)
                send(KIND_SEEK, $urandom_range(0, 255), $urandom_range(0, 2047), 1'b0);
            if ((k % 50) == 49)
                send(KIND_PEEK, $urandom_range(0, 255), $urandom_range(0, k + 2), 1'b0);
        end
        idle_on = 1'b1;
        for (k = 0; k < MAX_PATTERN; k++)
            send(KIND_PUSH, 8'hF0 + k, 11'd0, k == MAX_PATTERN - 1);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_PEEK, 8'h00, 11'd1023, 1'b0);
        send(KIND_PEEK, 8'h00, 11'd512, 1'b0);
        send(KIND_PEEK, 8'h00, 11'd1024, 1'b0);
        for (k = 0; k < 3; k++)
            send(KIND_PUSH, $urandom_range(0, 255), 11'd0, k == 2);
        set_config(1'b1, 64'hF7F6_F5F4_F3F2_F1F0, 4'd8);
        for (k = 0; k < 3; k++)
            send(KIND_PUSH, $urandom_range(0, 127), 11'd0, k == 2);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_POP, 8'h00, 11'd0, 1'b1);
        send(KIND_PUSH, 8'h7F, 11'd0, 1'b1);
        set_config(1'b1, '1, 4'd8);
        send(KIND_SEEK, 8'h00, 11'd0, 1'b0);
        send(KIND_PUSH, 8'h3C, 11'd0, 1'b0);
        send(KIND_DISCARD, 8'h00, 11'h7FF, 1'b0);

        // random phases over a spread of settings
        for (p = 0; p < 5; p++) begin
            sym_a = $urandom_range(0, 255);
            sym_b = $urandom_range(0, 255);
            for (k = 0; k < MAX_PATTERN; k++)
                pat[8*k +: 8] = $urandom_range(0, 1) ? sym_a : sym_b;
            case (p)
                0:       len = 4'd1;
                1:       len = 4'd8;
                2:       len = $urandom_range(2, 7);
                3:       len = $urandom_range(9, 15);
                default: len = 4'd0;
            endcase
            set_config(p[0], pat, len);
            idle_on = $urandom_range(0, 3) != 0;
            random_phase(80, sym_a, sym_b);
        end

        wait_idle();
        // let any stray result show up
        repeat (10) @(posedge clk);
        $display("%0d requests, %0d results checked; %0d seek hits, %0d overwrites,",
                 sb.n_req, sb.n_res, sb.n_found, sb.n_over);
        $display("%0d refused pushes, peak fill %0d, %0d mismatches",
                 sb.n_refused, sb.peak_fill, sb.fails);
        if (sb.fails == 0)
            $display("byte_ring_fifo_with_seek regression: pass");
        else
            $display("byte_ring_fifo_with_seek regression: fail");
        $finish;
    end
endmodule
